FILE: hw/rtl/sbsr_pkg.sv
`default_nettype none

package sbsr_pkg;

   // Input item: one received byte with a sensor snapshot, or a slider event.
   typedef struct packed {
      logic        operation;
      logic [7:0]  rx_byte;
      logic [14:0] sound_pulse;
      logic        light_high;
      logic        button_high;
      logic [9:0]  res_a;
      logic [9:0]  res_b;
      logic [9:0]  res_c;
      logic [9:0]  res_d;
      logic        up_button;
      logic        slider_down;
   } req_payload_type;

   // Result item: one byte of a report.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
      logic       comm_led;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLIDE_UP,
      ST_SLIDE_DN,
      ST_SOUND,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      UOP_SUB_SAT,
      UOP_ADD_SAT,
      UOP_HALVE
   } unit_op_type;

   // Results of the shared unit handed back to the sequencer.
   typedef struct packed {
      logic [14:0] result;
      logic        above_max;
   } unit_out_type;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SOUND_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SLIDER_STEP  = 2'd1;
   localparam logic [1:0] CSR_BLINK_PERIOD = 2'd2;

   localparam logic [7:0] REQ_CODE   = 8'h01;
   localparam logic [9:0] MAX_VALUE  = 10'd1023;
   localparam logic [4:0] LAST_INDEX = 5'd17;

   // Report channel codes.
   localparam logic [3:0] CH_ID     = 4'hF;
   localparam logic [3:0] CH_SLIDER = 4'h7;
   localparam logic [3:0] CH_LIGHT  = 4'h5;
   localparam logic [3:0] CH_SOUND  = 4'h6;
   localparam logic [3:0] CH_BUTTON = 4'h3;
   localparam logic [3:0] CH_RES_A  = 4'h4;
   localparam logic [3:0] CH_RES_B  = 4'h2;
   localparam logic [3:0] CH_RES_C  = 4'h1;
   localparam logic [3:0] CH_RES_D  = 4'h0;

   localparam logic [9:0] ID_VALUE = 10'd4;

endpackage

`default_nettype wire

FILE: hw/rtl/sensor_board_serial_reporter.sv
`default_nettype none

// Channel   Direction  Handshake        Payload
// req       in         valid / stall    sbsr_pkg::req_payload_type
// rsp       out        valid / stall    sbsr_pkg::rsp_payload_type
// csr       in         valid / ready    index (2 bits), data (10 bits)
//
// A report request is accepted, then with sound sampling on passes through the
// shared unit (up to five halvings and a store), then sends eighteen bytes of
// output, one byte per cycle when the output side does not stall.
// A slider event is accepted, then takes one shared-unit step for the up
// button and one for the down button. Other received bytes are accepted and dropped.
// Reset is synchronous and active high; it restores the register defaults, the
// slider, sound and request count to zero and the activity LED to on.
// A stall on the result side holds the current byte in the output register and
// pauses the byte output; the input side is stalled whenever the sequencer is busy.
module sensor_board_serial_reporter (
   input  var logic                      clock,
   input  var logic                      reset,

   input  var logic                      req_valid,
   output var logic                      req_stall,
   input  var sbsr_pkg::req_payload_type req_payload,

   output var logic                      rsp_valid,
   input  var logic                      rsp_stall,
   output var sbsr_pkg::rsp_payload_type rsp_payload,

   input  var logic                      csr_valid,
   output var logic                      csr_ready,
   input  var logic [1:0]                csr_index,
   input  var logic [9:0]                csr_data
);
   import sbsr_pkg::*;

   // Configuration registers.
   logic        sound_enable_ff;
   logic [9:0]  slider_step_ff;
   logic [7:0]  blink_period_ff;

   // Sequencer and block state.
   state_type       state_ff, state_in;
   logic [4:0]      index_ff, index_in;
   logic [9:0]      slider_ff, slider_in;
   logic [9:0]      sound_ff, sound_in;
   logic [7:0]      count_ff, count_in;
   logic            led_ff, led_in;
   logic [14:0]     pulse_ff, pulse_in;
   req_payload_type snap_ff, snap_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic req_fire;
   logic is_request;
   logic emit_load;
   logic slider_load;
   logic pulse_load;
   logic sound_load;

   unit_op_type  unit_op;
   logic [14:0]  unit_a;
   unit_out_type unit_out;

   logic [7:0] frame_byte;
   logic       frame_last;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign is_request  = !req_payload.operation && (req_payload.rx_byte == REQ_CODE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   sbsr_unit u_unit (
      .op        (unit_op),
      .operand_a (unit_a),
      .operand_b (slider_step_ff),
      .unit_out  (unit_out)
   );

   sbsr_framer u_framer (
      .byte_index   (index_ff),
      .slider_value (slider_ff),
      .sound_value  (sound_ff),
      .light_high   (snap_ff.light_high),
      .button_high  (snap_ff.button_high),
      .res_a        (snap_ff.res_a),
      .res_b        (snap_ff.res_b),
      .res_c        (snap_ff.res_c),
      .res_d        (snap_ff.res_d),
      .tx_byte      (frame_byte),
      .last_byte    (frame_last)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_payload.operation) begin
               state_in = ST_SLIDE_UP;
            end else if (req_fire && is_request) begin
               state_in = sound_enable_ff ? ST_SOUND : ST_EMIT;
            end
         end
         ST_SLIDE_UP: begin
            state_in = ST_SLIDE_DN;
         end
         ST_SLIDE_DN: begin
            state_in = ST_IDLE;
         end
         ST_SOUND: begin
            if (!unit_out.above_max) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_load && (index_ff == LAST_INDEX)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: shared unit operation and load strobes.
   always_comb begin
      unit_op     = UOP_HALVE;
      unit_a      = pulse_ff;
      slider_load = 1'b0;
      pulse_load  = 1'b0;
      sound_load  = 1'b0;
      emit_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SLIDE_UP: begin
            unit_op     = UOP_SUB_SAT;
            unit_a      = {5'd0, slider_ff};
            slider_load = snap_ff.up_button;
         end
         ST_SLIDE_DN: begin
            unit_op     = UOP_ADD_SAT;
            unit_a      = {5'd0, slider_ff};
            slider_load = snap_ff.slider_down;
         end
         ST_SOUND: begin
            // Halve while the pulse is above full scale, then store it.
            pulse_load = unit_out.above_max;
            sound_load = !unit_out.above_max;
         end
         ST_EMIT: begin
            emit_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   // Data path next values.
   always_comb begin
      snap_in        = snap_ff;
      pulse_in       = pulse_ff;
      slider_in      = slider_ff;
      sound_in       = sound_ff;
      count_in       = count_ff;
      led_in         = led_ff;
      index_in       = index_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (req_fire) begin
         snap_in  = req_payload;
         pulse_in = req_payload.sound_pulse;
         index_in = '0;
         if (is_request) begin
            if (count_ff == blink_period_ff) begin
               led_in   = !led_ff;
               count_in = '0;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end
      end
      if (slider_load) begin
         slider_in = unit_out.result[9:0];
      end
      if (pulse_load) begin
         pulse_in = unit_out.result;
      end
      if (sound_load) begin
         sound_in = pulse_ff[9:0];
      end
      if (emit_load) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.tx_byte   = frame_byte;
         rsp_payload_in.last_byte = frame_last;
         rsp_payload_in.comm_led  = led_ff;
         index_in                 = index_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         slider_ff    <= '0;
         sound_ff     <= '0;
         count_ff     <= '0;
         led_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         slider_ff    <= slider_in;
         sound_ff     <= sound_in;
         count_ff     <= count_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff        <= snap_in;
      pulse_ff       <= pulse_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Configuration writes; an index beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sound_enable_ff <= 1'b1;
         slider_step_ff  <= 10'd64;
         blink_period_ff <= 8'd15;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOUND_ENABLE: sound_enable_ff <= csr_data[0];
            CSR_SLIDER_STEP:  slider_step_ff  <= csr_data;
            CSR_BLINK_PERIOD: blink_period_ff <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sbsr_unit.sv
`default_nettype none

module sbsr_unit (
   input  var sbsr_pkg::unit_op_type  op,
   input  var logic [14:0]            operand_a,
   input  var logic [9:0]             operand_b,
   output var sbsr_pkg::unit_out_type unit_out
);
   import sbsr_pkg::*;

   logic [10:0] sum;

   assign sum = {1'b0, operand_a[9:0]} + {1'b0, operand_b};

   always_comb begin
      unit_out.above_max = (operand_a[14:10] != 5'd0);
      case (op)
         UOP_SUB_SAT: begin
            unit_out.result = (operand_a[9:0] > operand_b) ?
                              {5'd0, operand_a[9:0] - operand_b} : 15'd0;
         end
         UOP_ADD_SAT: begin
            unit_out.result = (sum > {1'b0, MAX_VALUE}) ?
                              {5'd0, MAX_VALUE} : {4'd0, sum};
         end
         UOP_HALVE: begin
            unit_out.result = {1'b0, operand_a[14:1]};
         end
         default: begin
            unit_out.result = operand_a;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/sbsr_framer.sv
`default_nettype none

module sbsr_framer (
   input  var logic [4:0]  byte_index,
   input  var logic [9:0]  slider_value,
   input  var logic [9:0]  sound_value,
   input  var logic        light_high,
   input  var logic        button_high,
   input  var logic [9:0]  res_a,
   input  var logic [9:0]  res_b,
   input  var logic [9:0]  res_c,
   input  var logic [9:0]  res_d,
   output var logic [7:0]  tx_byte,
   output var logic        last_byte
);
   import sbsr_pkg::*;

   logic [3:0] channel;
   logic [9:0] value;

   // Each tuple covers two bytes, so the tuple number is the index halved.
   always_comb begin
      case (byte_index[4:1])
         4'd0: begin channel = CH_ID;     value = ID_VALUE;                     end
         4'd1: begin channel = CH_SLIDER; value = slider_value;                 end
         4'd2: begin channel = CH_LIGHT;  value = light_high ? MAX_VALUE : '0;  end
         4'd3: begin channel = CH_SOUND;  value = sound_value;                  end
         4'd4: begin channel = CH_BUTTON; value = button_high ? MAX_VALUE : '0; end
         4'd5: begin channel = CH_RES_A;  value = res_a;                        end
         4'd6: begin channel = CH_RES_B;  value = res_b;                        end
         4'd7: begin channel = CH_RES_C;  value = res_c;                        end
         default: begin channel = CH_RES_D; value = res_d;                      end
      endcase
   end

   assign tx_byte   = byte_index[0] ? {1'b0, value[6:0]} : {1'b1, channel, value[9:7]};
   assign last_byte = (byte_index == LAST_INDEX);

endmodule

`default_nettype wire

FILE: test/sensor_board_serial_reporter_test.sv
`timescale 1ns / 1ps

// Values of the operation field of an input item.
localparam logic OP_RX_BYTE = 1'b0;
localparam logic OP_SLIDER  = 1'b1;

// Tracks the registers and the slider, sound, request count and LED of the
// reporter, builds the bytes each accepted item should produce and checks the
// bytes that come out against them in order.
class report_tracker;
   logic       sound_enable;
   logic [9:0] slider_step;
   logic [7:0] blink_period;
   logic [9:0] slider_value;
   logic [9:0] sound_value;
   logic [7:0] request_count;
   logic       led_level;
   sbsr_pkg::rsp_payload_type report_bytes[$];
   int mismatches;

   function new();
      sound_enable  = 1'b1;
      slider_step   = 10'd64;
      blink_period  = 8'd15;
      slider_value  = '0;
      sound_value   = '0;
      request_count = '0;
      led_level     = 1'b1;
      mismatches    = 0;
   endfunction

   function int pending();
      return report_bytes.size();
   endfunction

   task report_mismatch(string line);
      $display("%0t ns: %s", $time, line);
      mismatches++;
   endtask

   function void set_register(logic [1:0] index, logic [9:0] data);
      case (index)
         sbsr_pkg::CSR_SOUND_ENABLE: sound_enable = data[0];
         sbsr_pkg::CSR_SLIDER_STEP:  slider_step  = data;
         sbsr_pkg::CSR_BLINK_PERIOD: blink_period = data[7:0];
         default: ;
      endcase
   endfunction

   // One channel tuple: a header byte with the channel and the top value
   // bits, then a data byte with the low seven bits.
   function void push_tuple(logic [3:0] channel, logic [9:0] value, logic closing);
      sbsr_pkg::rsp_payload_type b;
      b.tx_byte   = {1'b1, channel, value[9:7]};
      b.last_byte = 1'b0;
      b.comm_led  = led_level;
      report_bytes.push_back(b);
      b.tx_byte   = {1'b0, value[6:0]};
      b.last_byte = closing;
      report_bytes.push_back(b);
   endfunction

   function void note_item(sbsr_pkg::req_payload_type item);
      logic [10:0] raised;
      logic [14:0] pulse;
      if (item.operation == OP_SLIDER) begin
         // The up button lowers the value and is applied before the down one.
         if (item.up_button) begin
            slider_value = (slider_value > slider_step) ? slider_value - slider_step : 10'd0;
         end
         if (item.slider_down) begin
            raised = {1'b0, slider_value} + {1'b0, slider_step};
            slider_value = (raised > {1'b0, sbsr_pkg::MAX_VALUE}) ?
                           sbsr_pkg::MAX_VALUE : raised[9:0];
         end
         return;
      end
      if (item.rx_byte != sbsr_pkg::REQ_CODE) begin
         return;
      end
      if (request_count == blink_period) begin
         led_level     = ~led_level;
         request_count = '0;
      end else begin
         request_count = request_count + 8'd1;
      end
      if (sound_enable) begin
         pulse = item.sound_pulse;
         while (pulse > 15'd1023) begin
            pulse = pulse >> 1;
         end
         sound_value = pulse[9:0];
      end
      push_tuple(sbsr_pkg::CH_ID, sbsr_pkg::ID_VALUE, 1'b0);
      push_tuple(sbsr_pkg::CH_SLIDER, slider_value, 1'b0);
      push_tuple(sbsr_pkg::CH_LIGHT, item.light_high ? sbsr_pkg::MAX_VALUE : 10'd0, 1'b0);
      push_tuple(sbsr_pkg::CH_SOUND, sound_value, 1'b0);
      push_tuple(sbsr_pkg::CH_BUTTON, item.button_high ? sbsr_pkg::MAX_VALUE : 10'd0, 1'b0);
      push_tuple(sbsr_pkg::CH_RES_A, item.res_a, 1'b0);
      push_tuple(sbsr_pkg::CH_RES_B, item.res_b, 1'b0);
      push_tuple(sbsr_pkg::CH_RES_C, item.res_c, 1'b0);
      push_tuple(sbsr_pkg::CH_RES_D, item.res_d, 1'b1);
   endfunction

   task check_byte(sbsr_pkg::rsp_payload_type got);
      sbsr_pkg::rsp_payload_type want;
      if (report_bytes.size() == 0) begin
         report_mismatch($sformatf("byte %02h arrived with no report pending", got.tx_byte));
         return;
      end
      want = report_bytes.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
         report_mismatch($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
      end
      if (got.last_byte !== want.last_byte) begin
         report_mismatch($sformatf("last_byte %b, expected %b",
                                   got.last_byte, want.last_byte));
      end
      if (got.comm_led !== want.comm_led) begin
         report_mismatch($sformatf("comm_led %b, expected %b", got.comm_led, want.comm_led));
      end
   endtask
endclass

module sensor_board_serial_reporter_test;
   import sbsr_pkg::*;

   // A slow but correct run stays well below this limit.
   localparam int CYCLE_LIMIT = 400000;
   // Wait after the last report is out; this covers a slider event or an
   // ignored byte still in flight after the last report.
   localparam int SETTLE_CYCLES = 40;

   typedef enum {
      KIND_REPORT,
      KIND_SLIDER,
      KIND_NOISE
   } item_kind_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [9:0]      csr_data;

   // While quiet is set, neither side starts a new idle burst.
   logic            quiet;
   int              stall_left = 0;
   int              cycles = 0;
   report_tracker   tracker;

   sensor_board_serial_reporter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side stalls in random bursts. A burst that
   // has started always runs out, even once the quiet stretch begins.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every byte taken from the result side is checked against the oldest
   // byte still expected.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_byte(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offers one item and holds it until the block takes it. The item is
   // handed to the tracker at the edge where it is accepted. Valid stays high
   // afterwards unless an idle burst follows, so back-to-back items never
   // lower and raise valid within one step.
   task automatic send_item(input req_payload_type item);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_item(item);
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Returns at a rising edge once every expected byte has come out. The
   // queue is looked at on falling edges so the check never races the monitor.
   task automatic wait_drained();
      do @(negedge clock); while (tracker.pending() != 0);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [9:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only with the block idle: every report is out and an
   // ignored item or slider event still in the sequencer has had time to end.
   task automatic set_config(input logic enable, input logic [9:0] step_size,
                             input logic [7:0] period);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_SOUND_ENABLE, {9'd0, enable});
      write_register(CSR_SLIDER_STEP, step_size);
      write_register(CSR_BLINK_PERIOD, {2'd0, period});
   endtask

   function automatic req_payload_type snapshot(input logic [7:0] rx, input logic [14:0] pulse,
                                                input logic light, input logic button,
                                                input logic [9:0] a, input logic [9:0] b,
                                                input logic [9:0] c, input logic [9:0] d);
      req_payload_type item;
      item.operation   = OP_RX_BYTE;
      item.rx_byte     = rx;
      item.sound_pulse = pulse;
      item.light_high  = light;
      item.button_high = button;
      item.res_a       = a;
      item.res_b       = b;
      item.res_c       = c;
      item.res_d       = d;
      item.up_button   = 1'b0;
      item.slider_down = 1'b0;
      return item;
   endfunction

   // The snapshot fields of a slider event carry random junk; the block must
   // not look at them.
   function automatic req_payload_type slider_event(input logic up, input logic down);
      req_payload_type item;
      item = snapshot(8'($urandom), 15'($urandom), 1'($urandom), 1'($urandom),
                      10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
      item.operation   = OP_SLIDER;
      item.up_button   = up;
      item.slider_down = down;
      return item;
   endfunction

   // Analog readings lean toward the ends of the range now and then.
   function automatic logic [9:0] pick_reading();
      case ($urandom_range(0, 7))
         0: return 10'd0;
         1: return MAX_VALUE;
         default: return 10'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_item(input item_kind_type kind);
      req_payload_type item;
      logic [14:0] pulse;
      case ($urandom_range(0, 3))
         0: pulse = 15'($urandom);
         1: pulse = 15'($urandom_range(0, 1023));
         2: pulse = 15'($urandom_range(1000, 1050));
         default: pulse = 15'($urandom_range(0, 4095));
      endcase
      item = snapshot(8'($urandom), pulse, 1'($urandom), 1'($urandom),
                      pick_reading(), pick_reading(), pick_reading(), pick_reading());
      item.up_button   = 1'($urandom);
      item.slider_down = 1'($urandom);
      case (kind)
         KIND_REPORT: item.rx_byte = REQ_CODE;
         KIND_SLIDER: item.operation = OP_SLIDER;
         default: begin
            if (item.rx_byte == REQ_CODE) begin
               item.rx_byte = ~REQ_CODE;
            end
         end
      endcase
      return item;
   endfunction

   // One random phase under one register setting. Reports, slider events and
   // ignored bytes all count toward the item total. Somewhere in the middle
   // the sender holds off until every expected byte is out. The last phase
   // runs without any idling.
   task automatic run_phase(input logic enable, input logic [9:0] step_size,
                            input logic [7:0] period, input bit last, input int count);
      int done;
      int pause_at;
      int pick;
      bit paused;
      item_kind_type kind;
      set_config(enable, step_size, period);
      if (last) begin
         quiet <= 1'b1;
      end
      pause_at = $urandom_range(count / 4, 3 * count / 4);
      paused   = 1'b0;
      done     = 0;
      while (done < count) begin
         if (!last && done % 24 == 0) begin
            quiet <= ($urandom_range(0, 3) == 0);
         end
         if (!last && !paused && done == pause_at) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            kind = KIND_REPORT;
         end else if (pick < 85) begin
            kind = KIND_SLIDER;
         end else begin
            kind = KIND_NOISE;
         end
         send_item(random_item(kind));
         done++;
      end
   endtask

   initial begin
      req_payload_type item;
      tracker = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_stall   <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_SOUND_ENABLE;
      csr_data    <= '0;
      quiet       <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values. The first reports
      // cover empty and full snapshots and the sound values on either side
      // of the halving threshold.
      send_item(snapshot(REQ_CODE, 15'd0, 1'b0, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0));
      send_item(snapshot(REQ_CODE, 15'h7FFF, 1'b1, 1'b1,
                         MAX_VALUE, MAX_VALUE, MAX_VALUE, MAX_VALUE));
      send_item(snapshot(REQ_CODE, 15'd1023, 1'b0, 1'b1,
                         10'h2AA, 10'h155, 10'h080, 10'h07F));
      send_item(snapshot(REQ_CODE, 15'd1024, 1'b1, 1'b0,
                         10'h155, 10'h2AA, 10'h07F, 10'h080));
      send_item(snapshot(REQ_CODE, 15'd2047, 1'b0, 1'b0,
                         10'h3FE, 10'h001, 10'h200, 10'h100));
      // Slider moves: up at zero saturates, down adds a step, both together
      // subtract first and then add.
      send_item(slider_event(1'b1, 1'b0));
      send_item(slider_event(1'b0, 1'b1));
      send_item(slider_event(1'b1, 1'b1));
      // A slider event carrying the request code still never reports.
      item = slider_event(1'b0, 1'b0);
      item.rx_byte = REQ_CODE;
      send_item(item);
      // A report ignores slider buttons set in its own item.
      item = snapshot(REQ_CODE, 15'd300, 1'b1, 1'b0, 10'd1, 10'd2, 10'd3, 10'd4);
      item.up_button   = 1'b1;
      item.slider_down = 1'b1;
      send_item(item);
      // Other received bytes are dropped together with their snapshot.
      send_item(snapshot(8'h00, 15'h7FFF, 1'b1, 1'b1,
                         MAX_VALUE, MAX_VALUE, MAX_VALUE, MAX_VALUE));
      send_item(snapshot(8'h02, 15'd5, 1'b1, 1'b0, 10'd9, 10'd9, 10'd9, 10'd9));
      send_item(snapshot(8'hFF, 15'd77, 1'b0, 1'b1, 10'd5, 10'd6, 10'd7, 10'd8));
      send_item(snapshot(8'h81, 15'd0, 1'b1, 1'b1, 10'd0, 10'd0, 10'd0, 10'd0));

      // Largest step: the slider saturates at the top and drops to zero.
      set_config(1'b1, 10'd1023, 8'd15);
      send_item(slider_event(1'b0, 1'b1));
      send_item(slider_event(1'b0, 1'b1));
      send_item(snapshot(REQ_CODE, 15'd4096, 1'b0, 1'b1,
                         10'd100, 10'd200, 10'd300, 10'd400));
      send_item(slider_event(1'b1, 1'b0));
      send_item(snapshot(REQ_CODE, 15'd1, 1'b1, 1'b0, 10'd0, MAX_VALUE, 10'd0, MAX_VALUE));

      // Zero step leaves the slider alone, sound sampling off keeps the last
      // sound value, and a blink period of zero toggles the LED every report.
      set_config(1'b0, 10'd0, 8'd0);
      send_item(slider_event(1'b0, 1'b1));
      send_item(snapshot(REQ_CODE, 15'd20000, 1'b0, 1'b0,
                         10'd11, 10'd22, 10'd33, 10'd44));
      send_item(snapshot(REQ_CODE, 15'd7, 1'b1, 1'b1, 10'd55, 10'd66, 10'd77, 10'd88));
      send_item(snapshot(REQ_CODE, 15'h7FFF, 1'b0, 1'b1,
                         MAX_VALUE, 10'd0, MAX_VALUE, 10'd0));

      // Random phases over the extremes of every register, then random
      // settings, and last a phase with no idling on either side.
      run_phase(1'b1, 10'd1, 8'd0, 1'b0, 68);
      run_phase(1'b0, 10'd1023, 8'd255, 1'b0, 68);
      run_phase(1'b1, 10'd0, 8'd3, 1'b0, 68);
      run_phase(1'($urandom), 10'($urandom_range(1, 1023)), 8'($urandom_range(0, 31)),
                1'b0, 68);
      run_phase(1'($urandom), 10'($urandom_range(1, 1023)), 8'($urandom), 1'b0, 68);
      run_phase(1'b1, 10'd64, 8'd15, 1'b1, 68);

      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
